// ----- design/lca_pkg.sv -----
// shared constants and types for the lowest common ancestor block
package lca_pkg;

   localparam int MAX_NODES  = 256;
   localparam int NODE_W     = 8;
   localparam int DEPTH_W    = 8;
   localparam int TABLE_SIZE = 1 << NODE_W;
   localparam int STEP_BOUND = 2 * MAX_NODES;
   localparam int STEP_W     = $clog2(STEP_BOUND + 1);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic [NODE_W-1:0]  parent;
      logic [DEPTH_W-1:0] depth;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] ancestor;
      logic              walk_failed;
   } result_type;

endpackage

// ----- design/tree_lowest_common_ancestor.sv -----
// lowest common ancestor by parent walk: one query or table write at a time
// a write gives no result
// a query makes steps parent moves before its result, steps being at most
// 2 * MAX_NODES; one move a cycle, set by the table read latency; no new
// item is taken until the walk has passed its result to the output register
// reset clears control and the result valid flag; the node table is not cleared
module tree_lowest_common_ancestor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [lca_pkg::NODE_W-1:0]  req_node_a,
   input  logic [lca_pkg::NODE_W-1:0]  req_node_b,
   input  logic [lca_pkg::NODE_W-1:0]  req_parent_value,
   input  logic [lca_pkg::DEPTH_W-1:0] req_depth_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lca_pkg::NODE_W-1:0]  rsp_ancestor,
   output logic                        rsp_walk_failed
);

   logic                       idle, req_take, wr_en, start, hold;
   lca_pkg::entry_type         wr_data, rd_data_a, rd_data_b;
   logic [lca_pkg::NODE_W-1:0] rd_addr_a, rd_addr_b;
   lca_pkg::result_type        result;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lca_pkg::NODE_W-1:0] ancestor_ff, ancestor_in;
   logic                       failed_ff, failed_in;

   assign req_stall = !idle;
   assign req_take  = req_valid && !req_stall;
   assign wr_en     = req_take && (req_mode == lca_pkg::MODE_WRITE);
   assign start     = req_take && (req_mode == lca_pkg::MODE_QUERY);
   assign hold      = rsp_valid_ff && rsp_stall;

   assign wr_data.parent = req_parent_value;
   assign wr_data.depth  = req_depth_value;

   // writes land only while idle, so a walk never overlaps a table update
   lca_table u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_node_a),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   lca_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .start_a   (req_node_a),
      .start_b   (req_node_b),
      .hold      (hold),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .idle      (idle),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      ancestor_in  = ancestor_ff;
      failed_in    = failed_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         ancestor_in  = result.ancestor;
         failed_in    = result.walk_failed;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ancestor_ff <= ancestor_in;
      failed_ff   <= failed_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ancestor    = ancestor_ff;
   assign rsp_walk_failed = failed_ff;

endmodule

// ----- design/lca_table.sv -----
// node table memory: one write port, two registered read ports
module lca_table (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lca_pkg::NODE_W-1:0] wr_addr,
   input  lca_pkg::entry_type         wr_data,
   input  logic [lca_pkg::NODE_W-1:0] rd_addr_a,
   input  logic [lca_pkg::NODE_W-1:0] rd_addr_b,
   output lca_pkg::entry_type         rd_data_a,
   output lca_pkg::entry_type         rd_data_b
);

   lca_pkg::entry_type mem [lca_pkg::TABLE_SIZE];
   lca_pkg::entry_type rd_a_ff;
   lca_pkg::entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- design/lca_walk.sv -----
// walk sequencer: raises the deeper node, then both nodes, one step a cycle
module lca_walk (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lca_pkg::NODE_W-1:0] start_a,
   input  logic [lca_pkg::NODE_W-1:0] start_b,
   input  logic                       hold,
   input  lca_pkg::entry_type         rd_data_a,
   input  lca_pkg::entry_type         rd_data_b,
   output logic [lca_pkg::NODE_W-1:0] rd_addr_a,
   output logic [lca_pkg::NODE_W-1:0] rd_addr_b,
   output logic                       idle,
   output lca_pkg::result_type        result
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   localparam logic [1:0] P_RAISE_B = 2'd0;
   localparam logic [1:0] P_RAISE_A = 2'd1;
   localparam logic [1:0] P_JOINT   = 2'd2;

   logic                       state_ff, state_in;
   logic [1:0]                 phase_ff, phase_in;
   logic [lca_pkg::NODE_W-1:0] a_ff, a_in;
   logic [lca_pkg::NODE_W-1:0] b_ff, b_in;
   logic [lca_pkg::STEP_W-1:0] steps_ff, steps_in;

   logic step_b, step_a, step_j, any_step, over, finish;

   always_comb begin
      // rd_data always belongs to the current a_ff / b_ff while walking
      step_b   = (phase_ff == P_RAISE_B) && (rd_data_a.depth < rd_data_b.depth);
      step_a   = !step_b && (phase_ff != P_JOINT) && (rd_data_b.depth < rd_data_a.depth);
      step_j   = !step_b && !step_a && (a_ff != b_ff);
      any_step = step_b || step_a || step_j;
      over     = steps_ff >= lca_pkg::STEP_W'(lca_pkg::STEP_BOUND);
      finish   = (state_ff == S_WALK) && (!any_step || over);

      state_in  = state_ff;
      phase_in  = phase_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      steps_in  = steps_ff;
      rd_addr_a = a_ff;
      rd_addr_b = b_ff;

      result.valid       = 1'b0;
      result.walk_failed = any_step && over;
      result.ancestor    = (any_step && over) ? '0 : a_ff;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr_a = start_a;
            rd_addr_b = start_b;
            if (start) begin
               state_in = S_WALK;
               phase_in = P_RAISE_B;
               a_in     = start_a;
               b_in     = start_b;
               steps_in = '0;
            end
         end
         S_WALK: begin
            if (finish) begin
               if (!hold) begin
                  result.valid = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               steps_in = steps_ff + 1'b1;
               if (step_b) begin
                  phase_in = P_RAISE_B;
                  b_in     = rd_data_b.parent;
               end else if (step_a) begin
                  phase_in = P_RAISE_A;
                  a_in     = rd_data_a.parent;
               end else begin
                  phase_in = P_JOINT;
                  a_in     = rd_data_a.parent;
                  b_in     = rd_data_b.parent;
               end
               rd_addr_a = a_in;
               rd_addr_b = b_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      steps_ff <= steps_in;
   end

   assign idle = (state_ff == S_IDLE);

endmodule

// ----- design/lca_checker.sv -----
// port-level checks for the lowest common ancestor block, bound to the top level
module lca_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        req_mode,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [lca_pkg::NODE_W-1:0]  rsp_ancestor,
   input logic                        rsp_walk_failed
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ancestor)
         && $stable(rsp_walk_failed))
      else $error("stalled result changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_walk_failed |-> rsp_ancestor == '0)
      else $error("failed walk with nonzero ancestor");

   // a query transfer keeps the input side busy for at least the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_mode == lca_pkg::MODE_QUERY |=> req_stall)
      else $error("input taken right after a query");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tree_lowest_common_ancestor lca_checker u_lca_checker (.*);

// ----- verif/tree_lowest_common_ancestor_tb.sv -----
// testbench for the lowest common ancestor block: table writes, ancestor queries, self-check
`timescale 1ns / 1ps

module tree_lowest_common_ancestor_tb;

   localparam int WATCHDOG_LIMIT = 8 * (lca_pkg::STEP_BOUND + 64);
   localparam int MAX_PRINTED    = 50;

   typedef struct {
      logic [lca_pkg::NODE_W-1:0] ancestor;
      logic                       walk_failed;
   } lca_answer_type;

   typedef enum int {STALL_NONE, STALL_SPARSE, STALL_BLOCK, STALL_COIN} stall_pattern_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_mode;
   logic [lca_pkg::NODE_W-1:0]  req_node_a;
   logic [lca_pkg::NODE_W-1:0]  req_node_b;
   logic [lca_pkg::NODE_W-1:0]  req_parent_value;
   logic [lca_pkg::DEPTH_W-1:0] req_depth_value;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [lca_pkg::NODE_W-1:0]  rsp_ancestor;
   logic                        rsp_walk_failed;

   // shadow copy of the node tables
   bit [lca_pkg::NODE_W-1:0]    tree_parent [lca_pkg::TABLE_SIZE];
   bit [lca_pkg::DEPTH_W-1:0]   tree_depth [lca_pkg::TABLE_SIZE];
   bit                          node_written [lca_pkg::TABLE_SIZE];
   logic [lca_pkg::NODE_W-1:0]  written_nodes [$];

   lca_answer_type              pending_answers [$];
   lca_answer_type              want_answer;
   int                          error_count = 0;
   int                          items_sent = 0;
   int                          burst_left = 0;
   int                          idle_cycles = 0;
   int                          stall_run = 0;
   stall_pattern_type           stall_kind = STALL_NONE;

   tree_lowest_common_ancestor u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .req_parent_value (req_parent_value),
      .req_depth_value  (req_depth_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ancestor     (rsp_ancestor),
      .rsp_walk_failed  (rsp_walk_failed)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) begin
         $display("%0t: mismatch: %s", $time, msg);
      end
      error_count++;
   endtask

   // raise the deeper node, then move both up together; flags reads of unwritten entries
   function automatic void predict_lca(input logic [lca_pkg::NODE_W-1:0] a_in,
                                       input logic [lca_pkg::NODE_W-1:0] b_in,
                                       output logic [lca_pkg::NODE_W-1:0] meet,
                                       output logic failed,
                                       output bit unwritten);
      logic [lca_pkg::NODE_W-1:0] a;
      logic [lca_pkg::NODE_W-1:0] b;
      int                         steps;
      a = a_in;
      b = b_in;
      steps = 0;
      meet = '0;
      failed = (int'(a) >= lca_pkg::MAX_NODES) || (int'(b) >= lca_pkg::MAX_NODES);
      unwritten = !node_written[a] || !node_written[b];
      while (!failed && tree_depth[a] < tree_depth[b]) begin
         if (steps >= lca_pkg::STEP_BOUND) begin
            failed = 1'b1;
         end else begin
            b = tree_parent[b];
            steps++;
            unwritten = unwritten | !node_written[b];
            failed = (int'(b) >= lca_pkg::MAX_NODES);
         end
      end
      while (!failed && tree_depth[b] < tree_depth[a]) begin
         if (steps >= lca_pkg::STEP_BOUND) begin
            failed = 1'b1;
         end else begin
            a = tree_parent[a];
            steps++;
            unwritten = unwritten | !node_written[a];
            failed = (int'(a) >= lca_pkg::MAX_NODES);
         end
      end
      while (!failed && a != b) begin
         if (steps >= lca_pkg::STEP_BOUND) begin
            failed = 1'b1;
         end else begin
            a = tree_parent[a];
            b = tree_parent[b];
            steps++;
            unwritten = unwritten | !node_written[a] | !node_written[b];
            failed = (int'(a) >= lca_pkg::MAX_NODES) || (int'(b) >= lca_pkg::MAX_NODES);
         end
      end
      if (!failed) begin
         meet = a;
      end
   endfunction

   task automatic send_item(input logic mode, input logic [lca_pkg::NODE_W-1:0] a,
                            input logic [lca_pkg::NODE_W-1:0] b,
                            input logic [lca_pkg::NODE_W-1:0] par_value,
                            input logic [lca_pkg::DEPTH_W-1:0] dep_value);
      lca_answer_type answer;
      bit             unwritten;
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_node_a       <= a;
      req_node_b       <= b;
      req_parent_value <= par_value;
      req_depth_value  <= dep_value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // transfer happened at this edge
      if (mode == lca_pkg::MODE_WRITE) begin
         if (int'(a) < lca_pkg::MAX_NODES) begin
            tree_parent[a] = par_value;
            tree_depth[a] = dep_value;
            if (!node_written[a]) begin
               node_written[a] = 1'b1;
               written_nodes.push_back(a);
            end
         end
      end else begin
         predict_lca(a, b, answer.ancestor, answer.walk_failed, unwritten);
         pending_answers.push_back(answer);
      end
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // a pair whose walk would touch a never written entry becomes a same-node query
   task automatic send_query(input logic [lca_pkg::NODE_W-1:0] a,
                             input logic [lca_pkg::NODE_W-1:0] b);
      logic [lca_pkg::NODE_W-1:0] meet;
      logic                       failed;
      bit                         unwritten;
      predict_lca(a, b, meet, failed, unwritten);
      if (unwritten) begin
         a = written_nodes[$urandom_range(0, written_nodes.size() - 1)];
         b = a;
      end
      send_item(lca_pkg::MODE_QUERY, a, b, lca_pkg::NODE_W'($urandom),
                lca_pkg::DEPTH_W'($urandom));
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic test_directed_tree();
      // 0 is the root, 1 and 255 its children, 2 and 3 under 1, 4 under 2
      send_item(lca_pkg::MODE_WRITE, 8'd0, 8'd255, 8'd0, 8'd0);
      send_item(lca_pkg::MODE_WRITE, 8'd1, 8'd0, 8'd0, 8'd1);
      send_item(lca_pkg::MODE_WRITE, 8'd255, 8'd0, 8'd0, 8'd1);
      send_item(lca_pkg::MODE_WRITE, 8'd2, 8'd0, 8'd1, 8'd2);
      send_item(lca_pkg::MODE_WRITE, 8'd3, 8'd0, 8'd1, 8'd2);
      send_item(lca_pkg::MODE_WRITE, 8'd4, 8'd0, 8'd2, 8'd3);
      send_query(8'd4, 8'd4);
      send_query(8'd4, 8'd3);
      send_query(8'd3, 8'd4);
      send_query(8'd255, 8'd4);
      send_query(8'd0, 8'd255);
      send_query(8'd2, 8'd4);
      // two nodes naming each other at equal depth: the walk runs to the bound
      send_item(lca_pkg::MODE_WRITE, 8'd200, 8'd0, 8'd201, 8'd5);
      send_item(lca_pkg::MODE_WRITE, 8'd201, 8'd0, 8'd200, 8'd5);
      send_query(8'd200, 8'd201);
      // a non-root self parent never gets shallower
      send_item(lca_pkg::MODE_WRITE, 8'd254, 8'hff, 8'd254, 8'd255);
      send_query(8'd254, 8'd254);
      send_query(8'd254, 8'd0);
      send_query(8'd4, 8'd254);
      send_item(lca_pkg::MODE_WRITE, 8'd5, 8'd0, 8'd254, 8'd1);
      send_query(8'd5, 8'd255);
      wait_for_answers();
   endtask

   task automatic test_random_forests();
      logic [lca_pkg::NODE_W-1:0] members [$];
      bit                         in_tree [lca_pkg::TABLE_SIZE];
      logic [lca_pkg::NODE_W-1:0] node;
      logic [lca_pkg::NODE_W-1:0] par_node;
      int                         target;
      int                         member_goal;
      int                         roll;
      target = items_sent + 1650;
      while (items_sent < target) begin
         members.delete();
         in_tree = '{default: 1'b0};
         node = lca_pkg::NODE_W'($urandom);
         members.push_back(node);
         in_tree[node] = 1'b1;
         send_item(lca_pkg::MODE_WRITE, node, lca_pkg::NODE_W'($urandom), node, '0);
         member_goal = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(2, 24);
         while (members.size() < member_goal && items_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               // broken entry: random parent and depth, may leave cycles behind
               send_item(lca_pkg::MODE_WRITE, lca_pkg::NODE_W'($urandom),
                         lca_pkg::NODE_W'($urandom), lca_pkg::NODE_W'($urandom),
                         lca_pkg::DEPTH_W'($urandom));
            end else if (roll < 6) begin
               send_query(written_nodes[$urandom_range(0, written_nodes.size() - 1)],
                          written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
            end else if (roll < 50) begin
               send_query(members[$urandom_range(0, members.size() - 1)],
                          members[$urandom_range(0, members.size() - 1)]);
            end else begin
               do node = lca_pkg::NODE_W'($urandom); while (in_tree[node]);
               // leaning on the newest member grows deeper chains
               par_node = ($urandom_range(0, 3) == 0) ? members[members.size() - 1]
                          : members[$urandom_range(0, members.size() - 1)];
               if (tree_depth[par_node] == '1) begin
                  par_node = members[0];
               end
               send_item(lca_pkg::MODE_WRITE, node, lca_pkg::NODE_W'($urandom), par_node,
                         tree_depth[par_node] + 1'b1);
               members.push_back(node);
               in_tree[node] = 1'b1;
            end
         end
         repeat ($urandom_range(4, 20)) begin
            send_query(members[$urandom_range(0, members.size() - 1)],
                       members[$urandom_range(0, members.size() - 1)]);
         end
         if ($urandom_range(0, 2) == 0) begin
            wait_for_answers();
         end
      end
   endtask

   task automatic test_deep_chain();
      logic [lca_pkg::NODE_W-1:0] order [lca_pkg::TABLE_SIZE];
      logic [lca_pkg::NODE_W-1:0] swap_node;
      int                         j;
      foreach (order[i]) order[i] = i[lca_pkg::NODE_W-1:0];
      for (int i = lca_pkg::TABLE_SIZE - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap_node = order[i];
         order[i] = order[j];
         order[j] = swap_node;
      end
      // one chain through every node, depths 0 up to 255
      send_item(lca_pkg::MODE_WRITE, order[0], lca_pkg::NODE_W'($urandom), order[0], '0);
      for (int i = 1; i < lca_pkg::TABLE_SIZE; i++) begin
         send_item(lca_pkg::MODE_WRITE, order[i], lca_pkg::NODE_W'($urandom), order[i-1],
                   i[lca_pkg::DEPTH_W-1:0]);
      end
      send_query(order[lca_pkg::TABLE_SIZE-1], order[0]);
      send_query(order[0], order[lca_pkg::TABLE_SIZE-1]);
      repeat (40) begin
         send_query(order[$urandom_range(0, lca_pkg::TABLE_SIZE - 1)],
                    order[$urandom_range(0, lca_pkg::TABLE_SIZE - 1)]);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, ancestor %0d failed %0b",
                                      rsp_ancestor, rsp_walk_failed));
         end else begin
            want_answer = pending_answers.pop_front();
            if (rsp_ancestor !== want_answer.ancestor) begin
               report_mismatch($sformatf("ancestor %0d, expected %0d",
                                         rsp_ancestor, want_answer.ancestor));
            end
            if (rsp_walk_failed !== want_answer.walk_failed) begin
               report_mismatch($sformatf("walk_failed %0b, expected %0b",
                                         rsp_walk_failed, want_answer.walk_failed));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
         stall_kind <= STALL_NONE;
      end else begin
         if (stall_run == 0) begin
            stall_run <= $urandom_range(1, 40);
            stall_kind <= stall_pattern_type'($urandom_range(0, 3));
         end else begin
            stall_run <= stall_run - 1;
         end
         case (stall_kind)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_BLOCK:  rsp_stall <= (stall_run > 25);
            default:      rsp_stall <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         report_mismatch("watchdog: no transfer for too long");
         $display("tree_lowest_common_ancestor_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_mode = lca_pkg::MODE_WRITE;
      req_node_a = '0;
      req_node_b = '0;
      req_parent_value = '0;
      req_depth_value = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_tree();
      test_random_forests();
      test_deep_chain();
      wait_for_answers();
      repeat (lca_pkg::STEP_BOUND + 40) @(posedge clock);
      if (error_count == 0) begin
         $display("tree_lowest_common_ancestor_tb: done, clean");
      end else begin
         $display("tree_lowest_common_ancestor_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/lca_pkg.sv
design/lca_table.sv
design/lca_walk.sv
design/tree_lowest_common_ancestor.sv
design/lca_checker.sv
verif/tree_lowest_common_ancestor_tb.sv
